>>> rtl/core/dqsv_pkg.sv
package dqsv_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int V_W    = 16;
    localparam int LIM_W  = 15;
    localparam int CNT_W  = 16;
    localparam int TRIG_W = 17;
    localparam int PH_W   = 54;

    localparam logic [14:0] SIN_A          = 15'd25736;
    localparam logic [13:0] SIN_B          = 14'd10512;
    localparam logic [10:0] SIN_C          = 11'd1160;
    localparam logic [15:0] SQRT3_HALF_Q16 = 16'd56756;

    localparam logic [15:0] SUPPLY_RST = 16'd3072;

    localparam int LIM_LAT  = 18;
    localparam int SIN_LAT  = 5;
    localparam int MIX_LAT  = 6;
    localparam int DUTY_LAT = 18;
    localparam int TOT_LAT  = LIM_LAT + MIX_LAT + DUTY_LAT;

    typedef enum logic [1:0] {
        CFG_VLIMIT = 2'd0,
        CFG_SUPPLY = 2'd1,
        CFG_PERIOD = 2'd2
    } t_cfg_idx;

endpackage

>>> rtl/core/dq_to_three_phase_svpwm.sv
// Channel   Valid     Stall     Payload
// input     i_valid   o_stall   i_vd, i_vq, i_theta
// output    o_valid   i_stall   o_compare_a/b/c, o_vd_applied, o_vq_applied
// config    i_cfg_we  -         i_cfg_index, i_cfg_data
//
// One request per cycle while o_stall is low; each request passes from input
// to the output register through the magnitude limiter's square-root search,
// Park/Clarke and injection, and the duty divider.
// Reset is synchronous; it clears the valid pipeline, voltage limit and PWM period and sets the supply to 3072.
// A one-entry skid buffer behind the output register keeps accepting while
// a result waits; o_stall rises only once that buffer is full.
module dq_to_three_phase_svpwm #(
    parameter int SINE_TABLE_BITS = dqsv_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_vd,
    input  logic signed [15:0] i_vq,
    input  logic        [15:0] i_theta,
    output logic               o_valid,
    input  logic               i_stall,
    output logic        [15:0] o_compare_a,
    output logic        [15:0] o_compare_b,
    output logic        [15:0] o_compare_c,
    output logic signed [15:0] o_vd_applied,
    output logic signed [15:0] o_vq_applied,
    input  logic               i_cfg_we,
    input  logic        [1:0]  i_cfg_index,
    input  logic        [15:0] i_cfg_data
);

    localparam int TOT  = dqsv_pkg::TOT_LAT;
    localparam int TDLY = dqsv_pkg::LIM_LAT - dqsv_pkg::SIN_LAT;
    localparam int ADLY = dqsv_pkg::MIX_LAT + dqsv_pkg::DUTY_LAT;
    localparam int TW   = dqsv_pkg::TRIG_W;

    logic [14:0] r_voltage_limit;
    logic [15:0] r_supply_voltage;
    logic [15:0] r_pwm_period;

    logic en;
    logic [TOT-1:0] r_vld;

    logic signed [15:0]   lim_vd, lim_vq;
    logic signed [TW-1:0] sin_v, cos_v;
    logic signed [TW-1:0] r_sin_dly [TDLY];
    logic signed [TW-1:0] r_cos_dly [TDLY];
    logic signed [15:0]   r_vd_dly [ADLY];
    logic signed [15:0]   r_vq_dly [ADLY];

    logic signed [32:0] r_t1_dc, r_t1_qs, r_t1_ds, r_t1_qc;
    logic signed [33:0] r_t2_alpha, r_t2_beta;
    logic signed [33:0] r_t3_alpha;
    logic signed [50:0] r_t3_bk;
    logic signed [51:0] r_t4_u [3];
    logic signed [51:0] r_t5_u [3];
    logic signed [51:0] r_t5_mn, r_t5_mx;
    logic signed [53:0] r_t6_p [3];
    logic signed [51:0] mn, mx;

    logic [15:0] cmp [3];

    logic               r_out_valid, r_skid_full;
    logic [15:0]        r_out_cmp [3];
    logic signed [15:0] r_out_vd, r_out_vq;
    logic [15:0]        r_skid_cmp [3];
    logic signed [15:0] r_skid_vd, r_skid_vq;
    logic               out_free, pipe_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voltage_limit  <= '0;
            r_supply_voltage <= dqsv_pkg::SUPPLY_RST;
            r_pwm_period     <= '0;
        end else if (i_cfg_we) begin
            case (dqsv_pkg::t_cfg_idx'(i_cfg_index))
                dqsv_pkg::CFG_VLIMIT: r_voltage_limit  <= i_cfg_data[14:0];
                dqsv_pkg::CFG_SUPPLY: r_supply_voltage <= i_cfg_data;
                dqsv_pkg::CFG_PERIOD: r_pwm_period     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en      = !r_skid_full;
    assign o_stall = r_skid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOT-2:0], i_valid};
        end
    end

    dqsv_limit u_limit (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_vd    (i_vd),
        .i_vq    (i_vq),
        .i_limit (r_voltage_limit),
        .o_vd    (lim_vd),
        .o_vq    (lim_vq)
    );

    dqsv_sine #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_theta (i_theta),
        .o_sin   (sin_v),
        .o_cos   (cos_v)
    );

    always_comb begin
        mn  = r_t4_u[0];
        mx  = r_t4_u[0];
        for (int k = 1; k < 3; k++) begin
            if (r_t4_u[k] < mn) mn = r_t4_u[k];
            if (r_t4_u[k] > mx) mx = r_t4_u[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sin_dly[0] <= sin_v;
            r_cos_dly[0] <= cos_v;
            for (int i = 1; i < TDLY; i++) begin
                r_sin_dly[i] <= r_sin_dly[i-1];
                r_cos_dly[i] <= r_cos_dly[i-1];
            end
            r_vd_dly[0] <= lim_vd;
            r_vq_dly[0] <= lim_vq;
            for (int i = 1; i < ADLY; i++) begin
                r_vd_dly[i] <= r_vd_dly[i-1];
                r_vq_dly[i] <= r_vq_dly[i-1];
            end

            r_t1_dc <= lim_vd * r_cos_dly[TDLY-1];
            r_t1_qs <= lim_vq * r_sin_dly[TDLY-1];
            r_t1_ds <= lim_vd * r_sin_dly[TDLY-1];
            r_t1_qc <= lim_vq * r_cos_dly[TDLY-1];

            r_t2_alpha <= 34'(r_t1_dc) - 34'(r_t1_qs);
            r_t2_beta  <= 34'(r_t1_ds) + 34'(r_t1_qc);

            r_t3_alpha <= r_t2_alpha;
            r_t3_bk    <= 51'(r_t2_beta) * $signed({1'b0, dqsv_pkg::SQRT3_HALF_Q16});

            r_t4_u[0] <= 52'(r_t3_alpha) <<< 16;
            r_t4_u[1] <= 52'(r_t3_bk) - (52'(r_t3_alpha) <<< 15);
            r_t4_u[2] <= 52'(52'sd0 - 52'(r_t3_bk)) - (52'(r_t3_alpha) <<< 15);

            r_t5_mn <= mn;
            r_t5_mx <= mx;
            for (int k = 0; k < 3; k++) begin
                r_t5_u[k] <= r_t4_u[k];
                r_t6_p[k] <= (54'(r_t5_u[k]) <<< 1) - (54'(r_t5_mn) + 54'(r_t5_mx));
            end
        end
    end

    dqsv_duty u_duty (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_p      (r_t6_p),
        .i_supply (r_supply_voltage),
        .i_period (r_pwm_period),
        .o_cmp    (cmp)
    );

    assign out_free   = !r_out_valid || !i_stall;
    assign pipe_valid = r_vld[TOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
                r_skid_full <= 1'b0;
            end
        end else if (pipe_valid) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_full <= 1'b1;
            end
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_full) begin
            if (out_free) begin
                r_out_cmp <= r_skid_cmp;
                r_out_vd  <= r_skid_vd;
                r_out_vq  <= r_skid_vq;
            end
        end else if (pipe_valid) begin
            if (out_free) begin
                r_out_cmp <= cmp;
                r_out_vd  <= r_vd_dly[ADLY-1];
                r_out_vq  <= r_vq_dly[ADLY-1];
            end else begin
                r_skid_cmp <= cmp;
                r_skid_vd  <= r_vd_dly[ADLY-1];
                r_skid_vq  <= r_vq_dly[ADLY-1];
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_compare_a  = r_out_cmp[0];
    assign o_compare_b  = r_out_cmp[1];
    assign o_compare_c  = r_out_cmp[2];
    assign o_vd_applied = r_out_vd;
    assign o_vq_applied = r_out_vq;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |-> r_out_valid)
        else $error("skid buffer full without a held output");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skid_full && pipe_valid && r_out_valid && i_stall) |=> r_skid_full)
        else $error("blocked result not captured in skid buffer");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |=> $stable(r_vld))
        else $error("pipeline advanced while skid buffer full");

endmodule

>>> rtl/core/dqsv_limit.sv
module dqsv_limit (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [dqsv_pkg::V_W-1:0]     i_vd,
    input  logic signed [dqsv_pkg::V_W-1:0]     i_vq,
    input  logic        [dqsv_pkg::LIM_W-1:0]   i_limit,
    output logic signed [dqsv_pkg::V_W-1:0]     o_vd,
    output logic signed [dqsv_pkg::V_W-1:0]     o_vq
);

    localparam int NB = dqsv_pkg::LIM_W;

    logic [15:0]        ad, aq;
    logic signed [31:0] sqd, sqq;
    logic [30:0]        adl, aql;
    logic [29:0]        lsq;

    logic signed [15:0] r_s1_vd, r_s1_vq;
    logic [30:0]        r_s1_sqd, r_s1_sqq;
    logic [30:0]        r_s1_adl, r_s1_aql;
    logic [29:0]        r_s1_lsq;

    logic [63:0]        r_p   [NB+1][2];
    logic [63:0]        r_q   [NB+1][2];
    logic [NB-1:0]      r_k   [NB+1][2];
    logic [61:0]        r_r   [NB+1][2];
    logic [31:0]        r_m   [NB+1];
    logic               r_scale [NB+1];
    logic signed [15:0] r_vd  [NB+1];
    logic signed [15:0] r_vq  [NB+1];

    logic [63:0]        cand  [NB+1][2];
    logic [31:0]        m_sum;

    logic signed [15:0] r_out_vd, r_out_vq;
    logic [15:0]        kd, kq;

    always_comb begin
        ad  = i_vd[15] ? 16'(-i_vd) : 16'(i_vd);
        aq  = i_vq[15] ? 16'(-i_vq) : 16'(i_vq);
        sqd = i_vd * i_vd;
        sqq = i_vq * i_vq;
        adl = ad * i_limit;
        aql = aq * i_limit;
        lsq = i_limit * i_limit;
        m_sum = {1'b0, r_s1_sqd} + {1'b0, r_s1_sqq};
    end

    always_comb begin
        for (int i = 0; i <= NB; i++) begin
            for (int ax = 0; ax < 2; ax++) begin
                cand[i][ax] = '0;
            end
        end
        for (int i = 1; i <= NB; i++) begin
            for (int ax = 0; ax < 2; ax++) begin
                cand[i][ax] = r_p[i-1][ax] + (r_q[i-1][ax] << (NB - i + 1))
                            + ({32'b0, r_m[i-1]} << (2 * (NB - i)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_vd  <= i_vd;
            r_s1_vq  <= i_vq;
            r_s1_sqd <= sqd[30:0];
            r_s1_sqq <= sqq[30:0];
            r_s1_adl <= adl;
            r_s1_aql <= aql;
            r_s1_lsq <= lsq;

            r_m[0]     <= m_sum;
            r_scale[0] <= m_sum > {2'b0, r_s1_lsq};
            r_vd[0]    <= r_s1_vd;
            r_vq[0]    <= r_s1_vq;
            r_r[0][0]  <= 62'(r_s1_adl) * 62'(r_s1_adl);
            r_r[0][1]  <= 62'(r_s1_aql) * 62'(r_s1_aql);
            for (int ax = 0; ax < 2; ax++) begin
                r_p[0][ax] <= '0;
                r_q[0][ax] <= '0;
                r_k[0][ax] <= '0;
            end

            for (int i = 1; i <= NB; i++) begin
                r_m[i]     <= r_m[i-1];
                r_scale[i] <= r_scale[i-1];
                r_vd[i]    <= r_vd[i-1];
                r_vq[i]    <= r_vq[i-1];
                for (int ax = 0; ax < 2; ax++) begin
                    r_r[i][ax] <= r_r[i-1][ax];
                    if (cand[i][ax] <= {2'b0, r_r[i-1][ax]}) begin
                        r_p[i][ax] <= cand[i][ax];
                        r_q[i][ax] <= r_q[i-1][ax] + ({32'b0, r_m[i-1]} << (NB - i));
                        r_k[i][ax] <= r_k[i-1][ax] | (NB'(1) << (NB - i));
                    end else begin
                        r_p[i][ax] <= r_p[i-1][ax];
                        r_q[i][ax] <= r_q[i-1][ax];
                        r_k[i][ax] <= r_k[i-1][ax];
                    end
                end
            end

            r_out_vd <= r_scale[NB] ? (r_vd[NB][15] ? 16'(16'd0 - kd) : kd) : r_vd[NB];
            r_out_vq <= r_scale[NB] ? (r_vq[NB][15] ? 16'(16'd0 - kq) : kq) : r_vq[NB];
        end
    end

    assign kd   = 16'(r_k[NB][0]);
    assign kq   = 16'(r_k[NB][1]);
    assign o_vd = r_out_vd;
    assign o_vq = r_out_vq;

endmodule

>>> rtl/core/dqsv_sine.sv
module dqsv_sine #(
    parameter int SINE_TABLE_BITS = dqsv_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic        [15:0]                    i_theta,
    output logic signed [dqsv_pkg::TRIG_W-1:0]    o_sin,
    output logic signed [dqsv_pkg::TRIG_W-1:0]    o_cos
);

    localparam int TB = SINE_TABLE_BITS;
    localparam int SH = 16 - TB;
    localparam int QB = TB - 2;

    logic [TB-1:0] idx;
    logic [1:0]    quad, cquad;
    logic [13:0]   x14;
    logic [14:0]   x0 [2];
    logic          n0 [2];

    logic [14:0] r1_x [2];
    logic        r1_n [2];
    logic [14:0] r2_x [2];
    logic [14:0] r2_x2 [2];
    logic        r2_n [2];
    logic [10:0] r3_t [2];
    logic [14:0] r3_x [2];
    logic [14:0] r3_x2 [2];
    logic        r3_n [2];
    logic [13:0] r4_t [2];
    logic [14:0] r4_x [2];
    logic        r4_n [2];
    logic signed [dqsv_pkg::TRIG_W-1:0] r5_y [2];

    logic [31:0] pr2 [2];
    logic [31:0] pr3 [2];
    logic [31:0] pr4 [2];
    logic [31:0] pr5 [2];
    logic [16:0] y5  [2];

    always_comb begin
        idx   = i_theta[15 -: TB];
        quad  = idx[TB-1 -: 2];
        cquad = quad + 2'd1;
        x14   = {idx[QB-1:0], {SH{1'b0}}};
        x0[0] = quad[0]  ? 15'(15'd16384 - {1'b0, x14}) : {1'b0, x14};
        x0[1] = cquad[0] ? 15'(15'd16384 - {1'b0, x14}) : {1'b0, x14};
        n0[0] = quad[1];
        n0[1] = cquad[1];
        for (int c = 0; c < 2; c++) begin
            pr2[c] = 32'(r1_x[c]) * 32'(r1_x[c]);
            pr3[c] = 32'(dqsv_pkg::SIN_C) * 32'(r2_x2[c]);
            pr4[c] = 32'(15'(dqsv_pkg::SIN_B) - 15'(r3_t[c])) * 32'(r3_x2[c]);
            pr5[c] = 32'(16'(dqsv_pkg::SIN_A) - 16'(r4_t[c])) * 32'(r4_x[c]);
            y5[c]  = 17'(pr5[c] >> 14);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 2; c++) begin
                r1_x[c]  <= x0[c];
                r1_n[c]  <= n0[c];
                r2_x[c]  <= r1_x[c];
                r2_x2[c] <= 15'(pr2[c] >> 14);
                r2_n[c]  <= r1_n[c];
                r3_t[c]  <= 11'(pr3[c] >> 14);
                r3_x[c]  <= r2_x[c];
                r3_x2[c] <= r2_x2[c];
                r3_n[c]  <= r2_n[c];
                r4_t[c]  <= 14'(pr4[c] >> 14);
                r4_x[c]  <= r3_x[c];
                r4_n[c]  <= r3_n[c];
                r5_y[c]  <= r4_n[c] ? $signed(17'd0 - y5[c]) : $signed(y5[c]);
            end
        end
    end

    assign o_sin = r5_y[0];
    assign o_cos = r5_y[1];

endmodule

>>> rtl/core/dqsv_duty.sv
module dqsv_duty (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [dqsv_pkg::PH_W-1:0]      i_p [3],
    input  logic        [15:0]                    i_supply,
    input  logic        [dqsv_pkg::CNT_W-1:0]     i_period,
    output logic        [dqsv_pkg::CNT_W-1:0]     o_cmp [3]
);

    localparam int QW = dqsv_pkg::CNT_W;

    logic [15:0]        sup;
    logic signed [55:0] half, full;
    logic signed [55:0] num [3];
    logic [45:0]        clmp [3];
    logic [61:0]        prod [3];
    logic [31:0]        dv   [QW+1];

    logic [45:0]   r1_num [3];
    logic [15:0]   r1_sup;
    logic [31:0]   r_rem  [QW+1][3];
    logic [QW-1:0] r_qt   [QW+1][3];
    logic [15:0]   r_sup  [QW+1];

    always_comb begin
        sup  = (i_supply == 16'd0) ? 16'd1 : i_supply;
        half = $signed({11'b0, sup, 29'b0});
        full = $signed({10'b0, sup, 30'b0});
        for (int k = 0; k < 3; k++) begin
            num[k] = half + 56'(i_p[k]);
            if (num[k] < 0) begin
                clmp[k] = '0;
            end else if (num[k] > full) begin
                clmp[k] = full[45:0];
            end else begin
                clmp[k] = num[k][45:0];
            end
            prod[k] = 62'(r1_num[k]) * 62'(i_period);
        end
        dv[0] = '0;
        for (int i = 1; i <= QW; i++) begin
            dv[i] = {16'b0, r_sup[i-1]} << (QW - i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sup   <= sup;
            r_sup[0] <= r1_sup;
            for (int k = 0; k < 3; k++) begin
                r1_num[k]   <= clmp[k];
                r_rem[0][k] <= prod[k][61:30];
                r_qt[0][k]  <= '0;
            end
            for (int i = 1; i <= QW; i++) begin
                r_sup[i] <= r_sup[i-1];
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[i-1][k] >= dv[i]) begin
                        r_rem[i][k] <= r_rem[i-1][k] - dv[i];
                        r_qt[i][k]  <= r_qt[i-1][k] | (QW'(1) << (QW - i));
                    end else begin
                        r_rem[i][k] <= r_rem[i-1][k];
                        r_qt[i][k]  <= r_qt[i-1][k];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_cmp[k] = r_qt[QW][k];
        end
    end

endmodule
